// ----- sv/ptct_pkg.sv -----
package ptct_pkg;

    // Request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_INC    = 3'd0;
    localparam logic [2:0] ST_INS    = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_DEC    = 3'd3;
    localparam logic [2:0] ST_REM    = 3'd4;
    localparam logic [2:0] ST_ABSENT = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;

    // Port field widths
    localparam int REQ_W   = 2;
    localparam int KEY_W   = 7;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic take;    // latch a new request word
        logic match;   // search the table, hold the hit slot
        logic update;  // write the table, register the result word
    } t_cmd;

endpackage

// ----- sv/ptct_ctrl.sv -----
module ptct_ctrl
    import ptct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // The update cycle writes the table at its closing edge, so a new word
    // may be taken at that same edge and matched against the fresh table.
    assign busy         = (r_state == S_MATCH);
    assign o_cmd.take   = start && !busy;
    assign o_cmd.match  = (r_state == S_MATCH);
    assign o_cmd.update = (r_state == S_UPDATE);

    always_comb begin
        case (r_state)
            S_IDLE: begin
                n_state = start ? S_MATCH : S_IDLE;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = start ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_take_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == S_MATCH)
        else $error("accepted word did not enter match");

    a_match_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MATCH |=> r_state == S_UPDATE)
        else $error("match not followed by update");

endmodule

// ----- sv/ptct_dp.sv -----
module ptct_dp
    import ptct_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16,
    parameter int KEY_BITS   = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [SLOT_W-1:0]  i_read_slot,
    output logic               o_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [KEY_W-1:0]   o_slot_key,
    output logic [COUNT_W-1:0] o_slot_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Table
    logic [KEY_BITS-1:0]   r_tkey [ENTRIES];
    logic [COUNT_BITS-1:0] r_tcnt [ENTRIES];
    logic [KEY_BITS-1:0]   n_tkey [ENTRIES];
    logic [COUNT_BITS-1:0] n_tcnt [ENTRIES];

    // Request word
    logic [REQ_W-1:0]    r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [SLOT_W-1:0]   r_rslot;

    // Match result
    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic             n_found;
    logic [IDX_W-1:0] n_idx;

    // Result word
    logic               r_valid;
    logic [STAT_W-1:0]  r_status;
    logic [SLOT_W-1:0]  r_slot;
    logic [KEY_W-1:0]   r_okey;
    logic [COUNT_W-1:0] r_ocnt;
    logic [STAT_W-1:0]  n_status;
    logic [SLOT_W-1:0]  n_slot;
    logic [KEY_W-1:0]   n_okey;
    logic [COUNT_W-1:0] n_ocnt;

    logic                  is_add;
    logic                  is_rem;
    logic [ENTRIES-1:0]    hit;
    logic                  rd_in_range;
    logic [IDX_W-1:0]      sel_idx;
    logic [IDX_W-1:0]      nxt_idx;
    logic                  has_nxt;
    logic [KEY_BITS-1:0]   cur_key;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [KEY_BITS-1:0]   nxt_key;
    logic [COUNT_BITS-1:0] nxt_cnt;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic [31:0]           idx_wide;

    assign is_add = (r_req == REQ_ADD);
    assign is_rem = (r_req == REQ_REMOVE);
    assign rd_in_range = (32'(r_rslot) < 32'(ENTRIES));

    // Add stops at the first empty slot or key match; remove needs a live match.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (is_add) begin
                hit[i] = (r_tcnt[i] == '0) || (r_tkey[i] == r_key);
            end else begin
                hit[i] = (r_tcnt[i] != '0) && (r_tkey[i] == r_key);
            end
        end
    end

    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        if (is_add || is_rem) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (hit[i]) begin
                    n_found = 1'b1;
                    n_idx   = IDX_W'(i);
                end
            end
        end else begin
            n_found = rd_in_range;
            n_idx   = IDX_W'(r_rslot);
        end
    end

    assign sel_idx  = r_found ? r_idx : '0;
    assign has_nxt  = (32'(sel_idx) < 32'(ENTRIES - 1));
    assign nxt_idx  = has_nxt ? IDX_W'(32'(sel_idx) + 32'd1) : '0;
    assign cur_key  = r_tkey[sel_idx];
    assign cur_cnt  = r_tcnt[sel_idx];
    assign nxt_key  = has_nxt ? r_tkey[nxt_idx] : '0;
    assign nxt_cnt  = has_nxt ? r_tcnt[nxt_idx] : '0;
    assign dec_cnt  = cur_cnt - COUNT_BITS'(1);
    assign idx_wide = 32'(sel_idx);

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            n_tkey[j] = r_tkey[j];
            n_tcnt[j] = r_tcnt[j];
        end
        n_status = ST_READ;
        n_slot   = r_rslot;
        n_okey   = '0;
        n_ocnt   = '0;

        if (is_add) begin
            if (r_found) begin
                n_slot = idx_wide[SLOT_W-1:0];
                if (cur_cnt == '0) begin
                    n_tkey[sel_idx] = r_key;
                    n_tcnt[sel_idx] = COUNT_BITS'(1);
                    n_status = ST_INS;
                    n_okey   = KEY_W'(32'(r_key));
                    n_ocnt   = COUNT_W'(1);
                end else begin
                    // hold at the maximum, still reported as an increment
                    if (cur_cnt != CNT_MAX) begin
                        n_tcnt[sel_idx] = cur_cnt + COUNT_BITS'(1);
                    end
                    n_status = ST_INC;
                    n_okey   = KEY_W'(32'(cur_key));
                    n_ocnt   = COUNT_W'(32'(n_tcnt[sel_idx]));
                end
            end else begin
                n_status = ST_FULL;
                n_slot   = '0;
            end
        end else if (is_rem) begin
            if (r_found) begin
                n_slot = idx_wide[SLOT_W-1:0];
                if (dec_cnt != '0) begin
                    n_tcnt[sel_idx] = dec_cnt;
                    n_status = ST_DEC;
                    n_okey   = KEY_W'(32'(cur_key));
                    n_ocnt   = COUNT_W'(32'(dec_cnt));
                end else begin
                    // close the gap: later entries move down one slot
                    for (int j = 0; j < ENTRIES - 1; j++) begin
                        if (32'(j) >= idx_wide) begin
                            n_tkey[j] = r_tkey[j+1];
                            n_tcnt[j] = r_tcnt[j+1];
                        end
                    end
                    n_tkey[ENTRIES-1] = '0;
                    n_tcnt[ENTRIES-1] = '0;
                    n_status = ST_REM;
                    n_okey   = KEY_W'(32'(nxt_key));
                    n_ocnt   = COUNT_W'(32'(nxt_cnt));
                end
            end else begin
                n_status = ST_ABSENT;
                n_slot   = '0;
            end
        end else begin
            if (r_found) begin
                n_okey = KEY_W'(32'(cur_key));
                n_ocnt = COUNT_W'(32'(cur_cnt));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ENTRIES; j++) begin
                r_tkey[j] <= '0;
                r_tcnt[j] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                for (int j = 0; j < ENTRIES; j++) begin
                    r_tkey[j] <= n_tkey[j];
                    r_tcnt[j] <= n_tcnt[j];
                end
            end
            r_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req   <= i_req_type;
            r_key   <= KEY_BITS'(i_key);
            r_rslot <= i_read_slot;
        end
        if (i_cmd.match) begin
            r_found <= n_found;
            r_idx   <= n_idx;
        end
        if (i_cmd.update) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_okey   <= n_okey;
            r_ocnt   <= n_ocnt;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_slot_key   = r_okey;
    assign o_slot_count = r_ocnt;

    a_valid_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.update))
        else $error("result word without an update cycle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status == ST_FULL || r_status == ST_ABSENT)
        |-> r_slot == '0 && r_okey == '0 && r_ocnt == '0)
        else $error("ignored request reported a slot");

    a_insert_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_INS |-> r_ocnt == COUNT_W'(1))
        else $error("inserted entry count not one");

    generate
        if (ENTRIES > 1) begin : g_packed
            for (genvar g = 0; g < ENTRIES - 1; g++) begin : g_chk
                a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                    r_tcnt[g+1] != '0 |-> r_tcnt[g] != '0)
                    else $error("table not packed at the front");
            end
        end
    endgenerate

endmodule

// ----- sv/packed_tile_count_table_unit.sv -----
// Packed (key, count) table. Raise start with a request word while busy is
// low: add a key (count rises, saturating, or the key takes the first empty
// slot with count one), remove a key (count falls; at zero the later entries
// close the gap), or read one slot (any other request code). Each word gives
// exactly one result word, shown for a single cycle with o_valid high once
// the update state registers it; the result cannot be held off, so capture
// it in that cycle. A word passes through two states: match searches all
// slots in parallel and picks the first hit, then update writes the table
// and registers the result. A new word may be given during the update state,
// so no idle state is needed between words. Reset empties the table at once.
module packed_tile_count_table_unit
    import ptct_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16,
    parameter int KEY_BITS   = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [SLOT_W-1:0]  i_read_slot,
    output logic               o_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [KEY_W-1:0]   o_slot_key,
    output logic [COUNT_W-1:0] o_slot_count
);

    t_cmd cmd;

    ptct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    ptct_dp #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_read_slot  (i_read_slot),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_slot_key   (o_slot_key),
        .o_slot_count (o_slot_count)
    );

endmodule

// ----- dv/packed_tile_count_table_unit_test.sv -----
module packed_tile_count_table_unit_test;
    import ptct_pkg::*;

    localparam int          ENTRIES    = 16;
    localparam int          COUNT_BITS = 16;
    localparam int          KEY_BITS   = 7;
    localparam logic [1:0]  REQ_READ   = 2'd2;
    localparam logic [1:0]  REQ_SPARE  = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int          RUN_LIMIT  = 2000000;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_tally_result;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] rs;
        bit                typed;
        t_tally_result     want;
    } t_tally_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [REQ_W-1:0]   i_req_type;
    logic [KEY_W-1:0]   i_key;
    logic [SLOT_W-1:0]  i_read_slot;
    logic               o_valid;
    logic [STAT_W-1:0]  o_status;
    logic [SLOT_W-1:0]  o_slot;
    logic [KEY_W-1:0]   o_slot_key;
    logic [COUNT_W-1:0] o_slot_count;

    logic [KEY_W-1:0]   tally_key   [ENTRIES];
    logic [COUNT_W-1:0] tally_count [ENTRIES];
    t_tally_result      pending_results [$];
    t_tally_row         directed_rows [$];
    logic [KEY_W-1:0]   key_pool [20];
    int                 mismatches = 0;

    packed_tile_count_table_unit #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_read_slot  (i_read_slot),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_slot_key   (o_slot_key),
        .o_slot_count (o_slot_count)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Apply one request word to the tally copy and return the result it gives
    function automatic t_tally_result tally_step(input logic [REQ_W-1:0] req,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [SLOT_W-1:0] rs);
        t_tally_result r;
        int hit;
        int i;
        r = '0;
        hit = -1;
        if (req == REQ_ADD) begin
            for (i = 0; i < ENTRIES; i++)
                if (hit < 0 && (tally_count[i] == '0 || tally_key[i] == key))
                    hit = i;
            if (hit < 0) begin
                r.status = ST_FULL;
            end else begin
                if (tally_count[hit] == '0) begin
                    tally_key[hit]   = key;
                    tally_count[hit] = COUNT_W'(1);
                    r.status = ST_INS;
                end else begin
                    if (tally_count[hit] != COUNT_MAX)
                        tally_count[hit] = tally_count[hit] + COUNT_W'(1);
                    r.status = ST_INC;
                end
                r.slot  = SLOT_W'(hit);
                r.key   = tally_key[hit];
                r.count = tally_count[hit];
            end
        end else if (req == REQ_REMOVE) begin
            for (i = 0; i < ENTRIES; i++)
                if (hit < 0 && tally_count[i] != '0 && tally_key[i] == key)
                    hit = i;
            if (hit < 0) begin
                r.status = ST_ABSENT;
            end else begin
                tally_count[hit] = tally_count[hit] - COUNT_W'(1);
                if (tally_count[hit] != '0) begin
                    r.status = ST_DEC;
                end else begin
                    // close the gap and empty the last slot
                    for (i = hit; i + 1 < ENTRIES; i++) begin
                        tally_key[i]   = tally_key[i+1];
                        tally_count[i] = tally_count[i+1];
                    end
                    tally_key[ENTRIES-1]   = '0;
                    tally_count[ENTRIES-1] = '0;
                    r.status = ST_REM;
                end
                r.slot  = SLOT_W'(hit);
                r.key   = tally_key[hit];
                r.count = tally_count[hit];
            end
        end else begin
            r.status = ST_READ;
            r.slot   = rs;
            if (rs < ENTRIES) begin
                r.key   = tally_key[rs];
                r.count = tally_count[rs];
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, 19)];
        return KEY_W'($urandom_range(0, 127));
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                           input logic [SLOT_W-1:0] rs, input bit typed,
                           input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] sl,
                           input logic [KEY_W-1:0] k, input logic [COUNT_W-1:0] c);
        t_tally_row row;
        row.req   = req;
        row.key   = key;
        row.rs    = rs;
        row.typed = typed;
        row.want  = '{status: st, slot: sl, key: k, count: c};
        directed_rows = {directed_rows, row};
    endtask

    // Offer one word, hold it until taken, then log what it should give
    task automatic issue_word(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                              input logic [SLOT_W-1:0] rs, input int idle_pct,
                              input bit typed, input t_tally_result want);
        int gap;
        t_tally_result predicted;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_key       <= key;
        i_read_slot <= rs;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predicted = tally_step(req, key, rs);
        pending_results = {pending_results, (typed ? want : predicted)};
    endtask

    always @(posedge i_clk) begin
        t_tally_result got;
        t_tally_result want;
        if (i_rst_n && o_valid) begin
            got = '{status: o_status, slot: o_slot, key: o_slot_key, count: o_slot_count};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d slot %0d key %0d count %0d",
                             got.status, got.slot, got.key, got.count);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.key !== want.key || got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.status, want.slot, want.key, want.count,
                                 got.status, got.slot, got.key, got.count);
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int i;
        int ph;
        int n;
        int r;
        int idle;
        int add_pct;
        logic [REQ_W-1:0] req;
        t_tally_result none;
        int phase_idle [4];
        int phase_add  [4];

        phase_idle = '{0, 62, 0, 31};
        phase_add  = '{55, 40, 50, 45};
        none = '0;
        for (i = 0; i < ENTRIES; i++) begin
            tally_key[i]   = '0;
            tally_count[i] = '0;
        end
        key_pool[0] = 7'd0;
        key_pool[1] = 7'd127;
        for (i = 2; i < 20; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 127));

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = '0;
        i_key       = '0;
        i_read_slot = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(REQ_READ,   7'd0,   4'd0,  1, ST_READ,   4'd0,  7'd0,   16'd0);
        add_row(REQ_READ,   7'd0,   4'd15, 1, ST_READ,   4'd15, 7'd0,   16'd0);
        add_row(REQ_REMOVE, 7'd5,   4'd0,  1, ST_ABSENT, 4'd0,  7'd0,   16'd0);
        add_row(REQ_ADD,    7'd0,   4'd0,  1, ST_INS,    4'd0,  7'd0,   16'd1);
        add_row(REQ_ADD,    7'd127, 4'd0,  1, ST_INS,    4'd1,  7'd127, 16'd1);
        add_row(REQ_ADD,    7'd0,   4'd0,  1, ST_INC,    4'd0,  7'd0,   16'd2);
        add_row(REQ_REMOVE, 7'd0,   4'd0,  0, ST_INC,    4'd0,  7'd0,   16'd0);
        add_row(REQ_REMOVE, 7'd0,   4'd0,  1, ST_REM,    4'd0,  7'd127, 16'd1);
        add_row(REQ_SPARE,  7'd0,   4'd0,  0, ST_INC,    4'd0,  7'd0,   16'd0);
        // fill the table up behind key 127
        for (i = 1; i < ENTRIES; i++)
            add_row(REQ_ADD, KEY_W'(i), 4'd0, 0, ST_INC, 4'd0, 7'd0, 16'd0);
        add_row(REQ_ADD,    7'd100, 4'd0,  1, ST_FULL,   4'd0,  7'd0,   16'd0);
        add_row(REQ_REMOVE, 7'd127, 4'd0,  0, ST_INC,    4'd0,  7'd0,   16'd0);
        add_row(REQ_READ,   7'd0,   4'd15, 1, ST_READ,   4'd15, 7'd0,   16'd0);

        foreach (directed_rows[i])
            issue_word(directed_rows[i].req, directed_rows[i].key, directed_rows[i].rs,
                       0, directed_rows[i].typed, directed_rows[i].want);

        for (ph = 0; ph < 4; ph++) begin
            add_pct = phase_add[ph];
            for (n = 0; n < 112; n++) begin
                r = $urandom_range(0, 99);
                if (r < add_pct)
                    req = REQ_ADD;
                else if (r < 88)
                    req = REQ_REMOVE;
                else if (r < 96)
                    req = REQ_READ;
                else
                    req = REQ_SPARE;
                // leave a burst without gaps every so often
                idle = (n % 30 < 8) ? 0 : phase_idle[ph];
                issue_word(req, pick_key(), SLOT_W'($urandom_range(0, 15)), idle, 0, none);
            end
        end

        issue_word(REQ_READ, 7'd0, 4'd0, 0, 0, none);
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ptct_pkg.sv
sv/ptct_ctrl.sv
sv/ptct_dp.sv
sv/packed_tile_count_table_unit.sv
dv/packed_tile_count_table_unit_test.sv
